// File: hw/rtl/decimal_text_to_int64_parser_unit_macros.svh
// Assertion macros shared by the parser unit's checker.
`ifndef DECIMAL_TEXT_TO_INT64_PARSER_UNIT_MACROS_SVH
`define DECIMAL_TEXT_TO_INT64_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define DTP_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/dtp_pkg.sv
// Types, constants and the int64-minimum literal table for the decimal parser.
`default_nettype none
package dtp_pkg;

  localparam int MAG_W       = 63;
  localparam int POS_W       = 5;
  localparam int MIN_LIT_LEN = 19;

  localparam logic [7:0] TERM_BYTE  = 8'h00;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [63:0] INT64_LOWEST = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_MIN    = 3'd4,
    PH_ERROR  = 3'd5
  } dtp_phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNTAX = 2'd1,
    ST_RANGE  = 2'd2
  } dtp_status_t;

  typedef struct packed {
    dtp_phase_t         phase;
    logic               is_negative;
    logic [MAG_W-1:0]   magnitude;
    logic               min_alive;
    logic [POS_W-1:0]   min_pos;
    dtp_status_t        first_error;
  } dtp_state_t;

  localparam dtp_state_t STATE_RESET = '{
    phase:       PH_LEAD,
    is_negative: 1'b0,
    magnitude:   '0,
    min_alive:   1'b0,
    min_pos:     '0,
    first_error: ST_OK
  };

  // Characters of 9223372036854775808, by position.
  function automatic logic [7:0] min_lit_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = "9";
      5'd1:    c = "2";
      5'd2:    c = "2";
      5'd3:    c = "3";
      5'd4:    c = "3";
      5'd5:    c = "7";
      5'd6:    c = "2";
      5'd7:    c = "0";
      5'd8:    c = "3";
      5'd9:    c = "6";
      5'd10:   c = "8";
      5'd11:   c = "5";
      5'd12:   c = "4";
      5'd13:   c = "7";
      5'd14:   c = "7";
      5'd15:   c = "5";
      5'd16:   c = "8";
      5'd17:   c = "0";
      5'd18:   c = "8";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/decimal_text_to_int64_parser_unit.sv
// Top level of the streaming decimal text to int64 parser.
//
// Slave side (s_*): one text byte per transfer. Whitespace, an optional sign,
// digits and trailing whitespace form a number; a byte of 0 ends the string.
// Master side (m_*): one result transfer per terminator, none for other bytes.
// Each result carries the signed 64-bit value (zero unless ok) and a status
// code: 0 ok, 1 invalid syntax, 2 out of range. The first error wins.
//
// Throughput: one byte per cycle, sustained while no terminator waits on a
// full result register. Each byte lands in an input register; from there the
// scanner updates its state with one multiply-by-ten add and range check,
// and a terminator loads the result register at the same edge and raises
// m_tvalid.
//
// Stall: while a result waits in the output register, non-terminator bytes
// keep flowing; a second terminator waits in the input register and
// s_tready drops until the result is taken.
//
// Reset (rst, synchronous): both registers empty, scanner back to the
// leading-whitespace phase with no error recorded.
`default_nettype none
module decimal_text_to_int64_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // [63:0] parsed_value, [65:64] parse_status, [71:66] zero
);
  import dtp_pkg::*;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;

  // scanner state
  dtp_state_t  scan;
  dtp_state_t  scan_next;

  // result register
  logic [63:0] out_value;
  dtp_status_t out_status;

  logic [63:0] step_value;
  dtp_status_t step_status;

  logic        out_free;
  logic        is_term;
  logic        step;

  dtp_scan_step u_step (
    .scan         (scan),
    .text_byte    (in_byte),
    .scan_next    (scan_next),
    .parsed_value (step_value),
    .parse_status (step_status)
  );

  assign out_free = !m_tvalid || m_tready;
  assign is_term  = (in_byte == TERM_BYTE);
  // a terminator needs room in the result register; other bytes never wait
  assign step     = in_valid && (!is_term || out_free);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      scan     <= STATE_RESET;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (step)     scan     <= scan_next;
      if (out_free) m_tvalid <= step && is_term;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) in_byte <= s_tdata;
    if (step && is_term) begin
      out_value  <= step_value;
      out_status <= step_status;
    end
  end

  assign m_tdata = {6'b0, out_status, out_value};

endmodule
`default_nettype wire

// File: hw/rtl/dtp_scan_step.sv
// Per-byte scanner step: next parse state and the result for a terminator.
`default_nettype none
module dtp_scan_step (
  input  dtp_pkg::dtp_state_t  scan,
  input  logic [7:0]           text_byte,
  output dtp_pkg::dtp_state_t  scan_next,
  output logic [63:0]          parsed_value,
  output dtp_pkg::dtp_status_t parse_status
);
  import dtp_pkg::*;

  logic               is_space;
  logic               is_digit;
  logic [3:0]         digit;
  logic [MAG_W+3:0]   wide;
  logic               overflow;
  logic               lit_hit;
  logic [POS_W-1:0]   pos_inc;
  logic               lit_done;
  logic               do_digit;
  logic               do_fail;
  dtp_status_t        fail_code;
  dtp_state_t         upd;

  assign is_space = (text_byte == CHAR_SPACE) || (text_byte inside {[8'h09:8'h0D]});
  assign is_digit = text_byte inside {[8'h30:8'h39]};
  assign digit    = text_byte[3:0];

  // magnitude * 10 + digit, wide enough that any excess over 2^63-1 shows above bit 62
  assign wide = ({4'b0, scan.magnitude} << 3) + ({4'b0, scan.magnitude} << 1)
              + {{MAG_W{1'b0}}, digit};
  assign overflow = |wide[MAG_W+3:MAG_W];

  assign lit_hit  = scan.min_alive && (scan.min_pos < POS_W'(MIN_LIT_LEN))
                 && (text_byte == min_lit_char(scan.min_pos));
  assign pos_inc  = POS_W'(scan.min_pos + 1'b1);
  assign lit_done = lit_hit && (pos_inc == POS_W'(MIN_LIT_LEN));

  always_comb begin
    upd       = scan;
    do_digit  = 1'b0;
    do_fail   = 1'b0;
    fail_code = ST_SYNTAX;

    case (scan.phase)
      PH_LEAD: begin
        if (is_space) begin
          upd.phase = PH_LEAD;
        end else if (text_byte == CHAR_MINUS) begin
          upd.is_negative = 1'b1;
          upd.min_alive   = 1'b1;
          upd.min_pos     = '0;
          upd.phase       = PH_SIGN;
        end else if (text_byte == CHAR_PLUS) begin
          upd.phase = PH_SIGN;
        end else if (is_digit) begin
          do_digit = 1'b1;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_SIGN: begin
        if (is_digit) do_digit = 1'b1;
        else          do_fail  = 1'b1;
      end
      PH_DIGITS: begin
        if (is_digit)      do_digit  = 1'b1;
        else if (is_space) upd.phase = PH_TRAIL;
        else               do_fail   = 1'b1;
      end
      PH_TRAIL, PH_MIN: begin
        if (!is_space) do_fail = 1'b1;
      end
      default: begin
        // error recorded: hold until the terminator
        upd = scan;
      end
    endcase

    if (do_digit) begin
      if (lit_hit) begin
        upd.min_pos = pos_inc;
      end else begin
        upd.min_alive = 1'b0;
      end
      if (lit_done) begin
        upd.phase = PH_MIN;
      end else if (overflow) begin
        do_fail   = 1'b1;
        fail_code = ST_RANGE;
      end else begin
        upd.magnitude = wide[MAG_W-1:0];
        upd.phase     = PH_DIGITS;
      end
    end

    if (do_fail) begin
      if (scan.first_error == ST_OK) upd.first_error = fail_code;
      upd.phase = PH_ERROR;
    end

    scan_next = (text_byte == TERM_BYTE) ? STATE_RESET : upd;
  end

  // Result as seen at the terminator
  always_comb begin
    parse_status = scan.first_error;
    parsed_value = '0;
    if (scan.first_error == ST_OK) begin
      case (scan.phase)
        PH_DIGITS, PH_TRAIL: begin
          parsed_value = scan.is_negative ? (64'd0 - {1'b0, scan.magnitude})
                                          : {1'b0, scan.magnitude};
        end
        PH_MIN: begin
          parsed_value = INT64_LOWEST;
        end
        default: begin
          parse_status = ST_SYNTAX;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dtp_checker.sv
// Port-level checks on the parser unit's result channel, bound to the top level.
`default_nettype none
`include "decimal_text_to_int64_parser_unit_macros.svh"
module dtp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata
);
  import dtp_pkg::*;

  logic code_known;
  logic err_status;

  assign code_known = (m_tdata[65:64] == ST_OK) || (m_tdata[65:64] == ST_SYNTAX)
                   || (m_tdata[65:64] == ST_RANGE);
  assign err_status = (m_tdata[65:64] != ST_OK);

  // stalled result must hold
  `DTP_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // status code is one of ok, syntax, range
  `DTP_ASSERT_NOW(a_status_code, clk, rst, m_tvalid, code_known, "bad status code")

  // any error forces a zero value
  `DTP_ASSERT_NOW(a_err_zero, clk, rst, m_tvalid && err_status, m_tdata[63:0] == 64'd0, "nonzero value with error status")

  // nothing on the result channel right after reset
  `DTP_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !m_tvalid, "result valid after reset")

endmodule

bind decimal_text_to_int64_parser_unit dtp_checker u_dtp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// File: tb/decimal_text_to_int64_parser_unit_tb.sv
// Self-checking testbench for the streaming decimal text to int64 parser.
`timescale 1ns / 1ps

module decimal_text_to_int64_parser_unit_tb;
  import dtp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [63:0] value;
    dtp_status_t status;
  } parse_result_t;

  // Tracks the scanner state for every accepted text byte and checks results.
  class int64_parse_checker;
    dtp_phase_t    phase;
    bit            neg;
    logic [62:0]   mag;
    bit            min_alive;
    logic [4:0]    min_pos;
    dtp_status_t   err_code;
    string         min_text = "9223372036854775808";
    parse_result_t pending_parses[$];
    int            fail_count;
    int            live_bytes;

    function new();
      clear_scan();
      fail_count = 0;
      live_bytes = 0;
    endfunction

    function void clear_scan();
      phase     = PH_LEAD;
      neg       = 1'b0;
      mag       = '0;
      min_alive = 1'b0;
      min_pos   = '0;
      err_code  = ST_OK;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void record_error(dtp_status_t code);
      if (err_code == ST_OK) err_code = code;
      phase = PH_ERROR;
    endfunction

    function void add_digit(logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - 8'h30);
      // still spelling out the int64 minimum right after a minus sign?
      if (min_alive && min_pos < MIN_LIT_LEN && c == min_text[min_pos]) begin
        min_pos++;
        if (min_pos == MIN_LIT_LEN) begin
          phase = PH_MIN;
          return;
        end
      end else begin
        min_alive = 1'b0;
      end
      if ({1'b0, mag} > (MAG_LIMIT - d) / 10) begin
        record_error(ST_RANGE);
        return;
      end
      mag   = 63'(mag * 10 + d);
      phase = PH_DIGITS;
    endfunction

    function void take_text_byte(logic [7:0] c);
      parse_result_t r;
      if (c == TERM_BYTE || phase != PH_ERROR) live_bytes++;
      if (c == TERM_BYTE) begin
        r.value  = '0;
        r.status = err_code;
        if (r.status == ST_OK) begin
          if (phase == PH_DIGITS || phase == PH_TRAIL)
            r.value = neg ? -{1'b0, mag} : {1'b0, mag};
          else if (phase == PH_MIN)
            r.value = INT64_LOWEST;
          else
            r.status = ST_SYNTAX;
        end
        if (r.status != ST_OK) r.value = '0;
        pending_parses.push_back(r);
        clear_scan();
        return;
      end
      case (phase)
        PH_LEAD: begin
          if (is_space(c)) begin
          end else if (c == CHAR_MINUS) begin
            neg       = 1'b1;
            min_alive = 1'b1;
            min_pos   = '0;
            phase     = PH_SIGN;
          end else if (c == CHAR_PLUS) begin
            phase = PH_SIGN;
          end else if (is_digit(c)) begin
            add_digit(c);
          end else begin
            record_error(ST_SYNTAX);
          end
        end
        PH_SIGN: begin
          if (is_digit(c)) add_digit(c);
          else record_error(ST_SYNTAX);
        end
        PH_DIGITS: begin
          if (is_digit(c)) add_digit(c);
          else if (is_space(c)) phase = PH_TRAIL;
          else record_error(ST_SYNTAX);
        end
        PH_TRAIL, PH_MIN: begin
          if (!is_space(c)) record_error(ST_SYNTAX);
        end
        default: begin
          // error already recorded, wait for the terminator
        end
      endcase
    endfunction

    function void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %h, actual %h", what, exp_v, act_v);
    endfunction

    function void check_parse_result(logic [71:0] td);
      parse_result_t e;
      if (pending_parses.size() == 0) begin
        flag("result with no pending string", '0, td[63:0]);
        return;
      end
      e = pending_parses.pop_front();
      if (td[63:0] !== e.value) flag("parsed_value", e.value, td[63:0]);
      if (td[65:64] !== e.status) flag("parse_status", 64'(e.status), 64'(td[65:64]));
      if (td[71:66] !== 6'd0) flag("padding", '0, 64'(td[71:66]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  int64_parse_checker sb;
  logic [7:0] line[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  decimal_text_to_int64_parser_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random back-pressure, plus a long hold-off when asked for.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result transfers are checked against the oldest pending string.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_parse_result(m_tdata);
  end

  // Watchdog: a hung block ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // One byte transfer, with a random number of idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_text_byte(b);
  endtask

  task automatic send_line();
    foreach (line[i]) send_byte(line[i]);
    send_byte(TERM_BYTE);
    line.delete();
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    add_text(s);
    send_line();
  endtask

  function automatic void add_ws(int n);
    int k;
    repeat (n) begin
      k = $urandom_range(5);
      line.push_back(k == 0 ? CHAR_SPACE : 8'(8'h08 + k));
    end
  endfunction

  function automatic void add_digits(int n);
    repeat (n) line.push_back(8'(8'h30 + $urandom_range(9)));
  endfunction

  function automatic void add_sign();
    case ($urandom_range(2))
      1: line.push_back(CHAR_PLUS);
      2: line.push_back(CHAR_MINUS);
      default: begin
      end
    endcase
  endfunction

  // Digit strings weighted toward the int64 boundaries.
  function automatic void add_number_body();
    case ($urandom_range(9))
      0: add_text("9223372036854775807");
      1: add_text("9223372036854775808");
      2: begin
        add_text("922337203685477580");
        add_digits(1);
      end
      3: add_digits($urandom_range(22, 17));
      4: begin
        repeat ($urandom_range(5, 1)) line.push_back("0");
        add_digits($urandom_range(19, 1));
      end
      5: add_digits(19);
      default: add_digits($urandom_range(12, 1));
    endcase
  endfunction

  function automatic void build_number();
    add_ws($urandom_range(2));
    add_sign();
    add_number_body();
    add_ws($urandom_range(2));
  endfunction

  task automatic send_random_line();
    int k;
    k = $urandom_range(99);
    if (k < 50) begin
      build_number();
    end else if (k < 60) begin
      // int64 minimum literal with assorted tails
      add_ws($urandom_range(1));
      line.push_back(CHAR_MINUS);
      add_text("9223372036854775808");
      case ($urandom_range(4))
        1: add_ws($urandom_range(3, 1));
        2: add_digits($urandom_range(2, 1));
        3: line.push_back(8'($urandom_range(255, 1)));
        4: begin
          add_ws(1);
          add_digits(1);
        end
        default: begin
        end
      endcase
    end else if (k < 80) begin
      // well-formed number with one byte inserted or replaced
      build_number();
      if ($urandom_range(1))
        line.insert($urandom_range(line.size()), 8'($urandom_range(255, 1)));
      else
        line[$urandom_range(line.size() - 1)] = 8'($urandom_range(255, 1));
    end else if (k < 90) begin
      repeat ($urandom_range(8)) line.push_back(8'($urandom_range(255, 1)));
    end else begin
      // blank, bare sign, or zero with an optional sign
      add_ws($urandom_range(3));
      add_sign();
      if ($urandom_range(1)) line.push_back("0");
      add_ws($urandom_range(2));
    end
    send_line();
  endtask

  // Sender goes idle until every expected result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_parses.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int send_pct, int recv_pct, int n_bytes);
    int target;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = sb.live_bytes + n_bytes;
    while (sb.live_bytes < target) send_random_line();
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: boundaries, signs, whitespace and error paths.
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    send_text("");
    send_text("   ");
    send_text("+");
    send_text("-");
    send_text("0");
    send_text("-0");
    send_text("+42");
    line = '{CHAR_SPACE, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, "1", "2", "3", 8'h0D, CHAR_SPACE};
    send_line();
    send_text("9223372036854775807");
    send_text("9223372036854775808");
    send_text("+9223372036854775808");
    send_text("-9223372036854775808");
    send_text("-9223372036854775809");
    send_text("-9223372036854775808 ");
    send_text("-92233720368547758080");
    send_text("-9223372036854775808x");
    send_text("12a");
    send_text("12 3");
    send_text("a1");
    send_text("- 5");
    send_text("99999999999999999999x");
    send_text("00000000000000000000042");
    line = '{8'hFF, "5"};
    send_line();
    line = '{8'h08, "1"};
    send_line();
    line = '{"7", 8'h0E};
    send_line();
    wait_drained();

    run_random(0, 0, 270);
    run_random(67, 0, 270);
    run_random(0, 67, 270);
    run_random(14, 14, 270);

    // Long receiver hold-off while terminators keep coming: the input
    // side has to stall once the output register and input register fill.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (12) begin
      add_sign();
      add_digits($urandom_range(3, 1));
      send_line();
    end
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending_parses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
